// ----- rtl/core/sse_pkg.sv -----
// sample statistics engine package: payload structs, run record, sequencer states
// no dependencies
`timescale 1ns / 1ps

package sse_pkg;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned IdxBits    = 10;
  localparam int unsigned CntBits    = 11;
  localparam int unsigned SumBits    = 26;
  localparam int unsigned SqBits     = 41;
  localparam int unsigned NumBits    = 52;
  localparam int unsigned DvsBits    = 21;
  localparam int unsigned VarBits    = 31;
  localparam int unsigned StdBits    = 16;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         last_sample;
  } in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] minimum;
    logic [IdxBits-1:0]           minimum_index;
    logic signed [SampleBits-1:0] maximum;
    logic [IdxBits-1:0]           maximum_index;
    logic [CntBits-1:0]           sample_count;
    logic signed [SampleBits-1:0] mean_value;
    logic [VarBits-1:0]           variance_value;
    logic [StdBits-1:0]           std_deviation;
    logic                         overflowed;
  } out_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] min_v;
    logic [IdxBits-1:0]           min_idx;
    logic signed [SampleBits-1:0] max_v;
    logic [IdxBits-1:0]           max_idx;
    logic [CntBits-1:0]           count;
    logic signed [SumBits-1:0]    sum;
    logic [SqBits-1:0]            sumsq;
    logic                         ovf;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIVM,
    ST_DIVV,
    ST_SQRT,
    ST_DONE
  } calc_state_e;

endpackage

// ----- rtl/core/sse_accum.sv -----
// front part: takes samples, keeps running count, sum, sum of squares, min and max
// depends on sse_pkg
`timescale 1ns / 1ps

module sse_accum (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  sse_pkg::in_t  in_i,
  output logic          rec_push_o,
  output sse_pkg::rec_t rec_o
);
  import sse_pkg::*;

  logic [CntBits-1:0]           count_q;
  logic signed [SumBits-1:0]    sum_q;
  logic [SqBits-1:0]            sumsq_q;
  logic signed [SampleBits-1:0] min_q, max_q;
  logic [IdxBits-1:0]           min_idx_q, max_idx_q;
  logic                         ovf_q;
  rec_t                         nxt;
  logic signed [2*SampleBits-1:0] sq;
  logic                         room;

  assign room = count_q < CntBits'(MaxSamples);
  assign sq   = in_i.sample * in_i.sample;

  always_comb begin
    nxt.min_v   = min_q;
    nxt.min_idx = min_idx_q;
    nxt.max_v   = max_q;
    nxt.max_idx = max_idx_q;
    nxt.count   = count_q;
    nxt.sum     = sum_q;
    nxt.sumsq   = sumsq_q;
    nxt.ovf     = ovf_q;
    if (room) begin
      if (count_q == '0) begin
        nxt.min_v   = in_i.sample;
        nxt.max_v   = in_i.sample;
        nxt.min_idx = '0;
        nxt.max_idx = '0;
      end else begin
        if (in_i.sample > max_q) begin
          nxt.max_v   = in_i.sample;
          nxt.max_idx = count_q[IdxBits-1:0];
        end
        if (in_i.sample < min_q) begin
          nxt.min_v   = in_i.sample;
          nxt.min_idx = count_q[IdxBits-1:0];
        end
      end
      nxt.sum   = sum_q + SumBits'(in_i.sample);
      nxt.sumsq = sumsq_q + SqBits'($unsigned(sq));
      nxt.count = count_q + CntBits'(1);
    end else begin
      nxt.ovf = 1'b1;
    end
  end

  assign rec_push_o = take_i && in_i.last_sample;
  assign rec_o      = nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      sumsq_q   <= '0;
      min_q     <= '0;
      max_q     <= '0;
      min_idx_q <= '0;
      max_idx_q <= '0;
      ovf_q     <= 1'b0;
    end else if (take_i) begin
      if (in_i.last_sample) begin
        count_q   <= '0;
        sum_q     <= '0;
        sumsq_q   <= '0;
        min_q     <= '0;
        max_q     <= '0;
        min_idx_q <= '0;
        max_idx_q <= '0;
        ovf_q     <= 1'b0;
      end else begin
        count_q   <= nxt.count;
        sum_q     <= nxt.sum;
        sumsq_q   <= nxt.sumsq;
        min_q     <= nxt.min_v;
        max_q     <= nxt.max_v;
        min_idx_q <= nxt.min_idx;
        max_idx_q <= nxt.max_idx;
        ovf_q     <= nxt.ovf;
      end
    end
  end

endmodule

// ----- rtl/core/sse_queue.sv -----
// two-entry queue of finished run records between front and back
// depends on sse_pkg
`timescale 1ns / 1ps

module sse_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sse_pkg::rec_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sse_pkg::rec_t rdata_o
);
  import sse_pkg::*;

  rec_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign rdata_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- rtl/core/sse_calc.sv -----
// back part: mean, variance and deviation by one shared bit-serial divider and a root loop
// depends on sse_pkg
`timescale 1ns / 1ps

module sse_calc (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  sse_pkg::rec_t q_data_i,
  output logic          q_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output sse_pkg::out_t res_o
);
  import sse_pkg::*;

  localparam int unsigned DivSteps  = NumBits;
  localparam int unsigned SqrtSteps = StdBits;

  calc_state_e              state_q, state_d;
  rec_t                     rec_q;
  out_t                     res_q;
  logic [NumBits-1:0]       prod_q, num_q, dvd_q, dvd_d;
  logic [SumBits-1:0]       am_q;
  logic [DvsBits-1:0]       dvs_q;
  logic [DvsBits:0]         rem_q, rem_d, rem_s;
  logic [5:0]               cnt_q;
  logic                     ge, neg, last_step;
  logic [16:0]              q17, mean17;
  logic [31:0]              x_q, root_q, bit_q, x_d, r_d, t;

  always_comb begin
    rem_s = {rem_q[DvsBits-1:0], dvd_q[NumBits-1]};
    ge    = rem_s >= {1'b0, dvs_q};
    rem_d = ge ? rem_s - {1'b0, dvs_q} : rem_s;
    dvd_d = {dvd_q[NumBits-2:0], ge};
  end

  always_comb begin
    t = root_q + bit_q;
    if (x_q >= t) begin
      x_d = x_q - t;
      r_d = (root_q >> 1) + bit_q;
    end else begin
      x_d = x_q;
      r_d = root_q >> 1;
    end
  end

  assign neg    = rec_q.sum < 0;
  assign q17    = dvd_d[16:0];
  assign mean17 = neg ? (17'd0 - q17 - 17'(rem_d != '0)) : q17;

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    last_step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DIVM;
      ST_DIVM: begin
        last_step = cnt_q == 6'(DivSteps - 1);
        if (last_step) state_d = ST_DIVV;
      end
      ST_DIVV: begin
        last_step = cnt_q == 6'(DivSteps - 1);
        if (last_step) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        last_step = cnt_q == 6'(SqrtSteps - 1);
        if (last_step) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (pop_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        rec_q <= q_data_i;
      end
      ST_MUL1: begin
        prod_q <= NumBits'(rec_q.count) * NumBits'(rec_q.sumsq);
        am_q   <= neg ? SumBits'(-rec_q.sum) : SumBits'(rec_q.sum);
      end
      ST_MUL2: begin
        num_q <= prod_q - NumBits'(am_q) * NumBits'(am_q);
        dvd_q <= NumBits'(am_q);
        dvs_q <= DvsBits'(rec_q.count);
        rem_q <= '0;
        cnt_q <= '0;
        res_q.minimum       <= rec_q.min_v;
        res_q.minimum_index <= rec_q.min_idx;
        res_q.maximum       <= rec_q.max_v;
        res_q.maximum_index <= rec_q.max_idx;
        res_q.sample_count  <= rec_q.count;
        res_q.overflowed    <= rec_q.ovf;
      end
      ST_DIVM: begin
        if (last_step) begin
          res_q.mean_value <= mean17[15:0];
          dvd_q <= num_q;
          dvs_q <= DvsBits'(rec_q.count) * DvsBits'(rec_q.count);
          rem_q <= '0;
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 6'd1;
          dvd_q <= dvd_d;
          rem_q <= rem_d;
        end
      end
      ST_DIVV: begin
        if (last_step) begin
          res_q.variance_value <= dvd_d[VarBits-1:0];
          x_q    <= 32'(dvd_d[VarBits-1:0]);
          root_q <= '0;
          bit_q  <= 32'd1 << 30;
          cnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + 6'd1;
          dvd_q <= dvd_d;
          rem_q <= rem_d;
        end
      end
      ST_SQRT: begin
        cnt_q  <= cnt_q + 6'd1;
        x_q    <= x_d;
        root_q <= r_d;
        bit_q  <= bit_q >> 2;
        if (last_step) res_q.std_deviation <= r_d[StdBits-1:0];
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign empty_o = state_q != ST_DONE;
  assign res_o   = res_q;

endmodule

// ----- rtl/core/sample_statistics_engine.sv -----
// sample statistics engine: one sample a cycle into running sums while the record queue is not full, result per run
// path: the record of the marked last sample goes through the record queue, then MUL1, MUL2, DIVM, DIVV, SQRT, DONE
// throughput: one sample per cycle while the record queue is not full; new runs are taken while the back works on one
// reset: rst_ni low clears all running sums, the record queue and the back sequencer
// depends on sse_pkg, sse_accum, sse_queue, sse_calc
`timescale 1ns / 1ps

module sample_statistics_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  sse_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output sse_pkg::out_t out_o
);
  import sse_pkg::*;

  logic take, rec_push, q_full, q_empty, q_pop;
  rec_t rec, q_data;

  assign full = q_full;
  assign take = push && !q_full;

  sse_accum u_accum (
    .clk_i,
    .rst_ni,
    .take_i     (take),
    .in_i,
    .rec_push_o (rec_push),
    .rec_o      (rec)
  );

  sse_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (rec_push),
    .wdata_i (rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  sse_calc u_calc (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (out_o)
  );

endmodule

// ----- tb/sample_statistics_engine_tb.sv -----
// testbench for sample_statistics_engine: directed table, capacity runs, then random runs of samples,
// every result checked field by field against a behavioural predictor of the run statistics
// depends on sse_pkg and the sample_statistics_engine rtl
`timescale 1ns / 1ps

module sample_statistics_engine_tb;
  import sse_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic  clk_i;
  logic  rst_ni;
  logic  push;
  logic  full;
  in_t   in_i;
  logic  empty;
  logic  pop;
  out_t  out_o;

  sample_statistics_engine dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (in_i),
    .empty (empty),
    .pop   (pop),
    .out_o (out_o)
  );

  // running state of the predictor
  int unsigned     run_count;
  longint          run_sum;
  longint unsigned run_sumsq;
  longint          run_min;
  longint          run_max;
  int unsigned     run_min_idx;
  int unsigned     run_max_idx;
  bit              run_ovf;

  out_t        stats_due[$];
  int unsigned mismatches;
  int unsigned cycles;

  typedef struct {
    logic signed [15:0] smp;
    bit                 lst;
    bit                 typed;
    out_t               want;
  } row_t;

  row_t rows[$];

  function automatic out_t mk_out(longint mn, int mi, longint mx, int xi, int n, longint mean,
                                  longint unsigned var_v, longint unsigned sd, bit ov);
    out_t o;
    o.minimum        = mn[15:0];
    o.minimum_index  = mi[9:0];
    o.maximum        = mx[15:0];
    o.maximum_index  = xi[9:0];
    o.sample_count   = n[10:0];
    o.mean_value     = mean[15:0];
    o.variance_value = var_v[30:0];
    o.std_deviation  = sd[15:0];
    o.overflowed     = ov;
    return o;
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void clear_run();
    run_count = 0; run_sum = 0; run_sumsq = 0; run_min = 0; run_max = 0;
    run_min_idx = 0; run_max_idx = 0; run_ovf = 0;
  endfunction

  // returns 1 and the statistics when the sample closes a run
  function automatic bit predict_stats(logic signed [15:0] smp, bit lst, output out_t res);
    longint          s;
    longint          n;
    longint          q;
    longint unsigned am;
    longint unsigned v;
    s = smp;
    res = '0;
    if (run_count < MaxSamples) begin
      if (run_count == 0) begin
        run_min = s; run_max = s; run_min_idx = 0; run_max_idx = 0;
      end else begin
        if (s > run_max) begin run_max = s; run_max_idx = run_count; end
        if (s < run_min) begin run_min = s; run_min_idx = run_count; end
      end
      run_sum += s;
      run_sumsq += longint'(s * s);
      run_count++;
    end else begin
      run_ovf = 1;
    end
    if (!lst) return 0;
    n = run_count;
    q = 0;
    v = 0;
    if (n != 0) begin
      q = run_sum / n;
      if ((run_sum % n) != 0 && run_sum < 0) q--;
      am = (run_sum < 0) ? -run_sum : run_sum;
      v = (longint'(n) * run_sumsq - am * am) / longint'(n * n);
    end
    res = mk_out(run_min, run_min_idx, run_max, run_max_idx, n, q, v, int_root(v), run_ovf);
    clear_run();
    return 1;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic check_stats(out_t got);
    out_t w;
    if (stats_due.size() == 0) begin
      report("unexpected result", 1, 0);
      return;
    end
    w = stats_due.pop_front();
    if (got.minimum !== w.minimum) report("minimum", got.minimum, w.minimum);
    if (got.minimum_index !== w.minimum_index)
      report("minimum_index", got.minimum_index, w.minimum_index);
    if (got.maximum !== w.maximum) report("maximum", got.maximum, w.maximum);
    if (got.maximum_index !== w.maximum_index)
      report("maximum_index", got.maximum_index, w.maximum_index);
    if (got.sample_count !== w.sample_count)
      report("sample_count", got.sample_count, w.sample_count);
    if (got.mean_value !== w.mean_value) report("mean_value", got.mean_value, w.mean_value);
    if (got.variance_value !== w.variance_value)
      report("variance_value", got.variance_value, w.variance_value);
    if (got.std_deviation !== w.std_deviation)
      report("std_deviation", got.std_deviation, w.std_deviation);
    if (got.overflowed !== w.overflowed) report("overflowed", got.overflowed, w.overflowed);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // sends one sample and, when it closes a run, queues the expected statistics of that run
  task automatic send_sample(logic signed [15:0] smp, bit lst, bit typed, out_t want);
    out_t res;
    int   gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i.sample <= smp;
    in_i.last_sample <= lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (predict_stats(smp, lst, res)) begin
      if (typed && res !== want) report("table row", 1, 0);
      stats_due.push_back(res);
    end
  endtask

  task automatic add_row(logic signed [15:0] smp, bit lst, bit typed, out_t want);
    row_t r;
    r.smp = smp; r.lst = lst; r.typed = typed; r.want = want;
    rows.push_back(r);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (stats_due.size() != 0) @(posedge clk_i);
  endtask

  // result side: random pop stalls
  initial begin
    int stall;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      check_stats(out_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sample_statistics_engine test failed");
      $finish;
    end
  end

  initial begin
    int   len;
    int   mode;
    int   bias;
    logic signed [15:0] smp;
    out_t none;
    none = '0;
    mismatches = 0;
    push <= 1'b0;
    in_i <= '0;
    rst_ni <= 1'b0;
    clear_run();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-sample runs at the extremes and at zero
    add_row(16'sh7fff, 1, 1, mk_out(32767, 0, 32767, 0, 1, 32767, 0, 0, 0));
    add_row(-16'sh8000, 1, 1, mk_out(-32768, 0, -32768, 0, 1, -32768, 0, 0, 0));
    add_row(16'sh0000, 1, 1, mk_out(0, 0, 0, 0, 1, 0, 0, 0, 0));
    // two extremes: widest variance
    add_row(-16'sh8000, 0, 0, none);
    add_row(16'sh7fff, 1, 1, mk_out(-32768, 0, 32767, 1, 2, -1, 1073709056, 32767, 0));
    // ties keep the first index
    add_row(16'sh0005, 0, 0, none);
    add_row(16'sh0005, 0, 0, none);
    add_row(-16'sh0003, 0, 0, none);
    add_row(-16'sh0003, 0, 0, none);
    add_row(16'sh0005, 1, 0, none);
    // negative mean floors down
    add_row(-16'sh0001, 0, 0, none);
    add_row(16'sh0000, 1, 0, none);
    add_row(-16'sh0007, 0, 0, none);
    add_row(-16'sh0002, 0, 0, none);
    add_row(16'sh0003, 1, 0, none);
    add_row(16'sh5555, 0, 0, none);
    add_row(-16'sh2aab, 1, 0, none);
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].lst, rows[i].typed, rows[i].want);

    // over-long run: full capacity, then ignored samples, marked last ignored too
    for (int i = 0; i < MaxSamples + 3; i++)
      send_sample(16'($urandom()), i == MaxSamples + 2, 0, none);
    // exactly full
    for (int i = 0; i < MaxSamples; i++)
      send_sample((i % 2) ? 16'sh7fff : -16'sh8000, i == MaxSamples - 1, 0, none);

    // sender waits for all results
    wait_drained();

    for (int items = 0; items < 500;) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      mode = $urandom_range(0, 3);
      bias = $urandom_range(0, 255);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: smp = 16'($urandom());
          1: smp = $urandom_range(0, 1) ? 16'(16'sh7fff - $urandom_range(0, 3))
                                         : 16'(-16'sh8000 + $urandom_range(0, 3));
          2: smp = 16'(bias + $urandom_range(0, 3) - 2);
          default: smp = 16'(-bias - $urandom_range(0, 3));
        endcase
        send_sample(smp, k == len - 1, 0, none);
        items++;
      end
      if ($urandom_range(0, 40) == 0) wait_drained();
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sample_statistics_engine test passed");
    end else begin
      $display("sample_statistics_engine test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sse_pkg.sv
rtl/core/sse_accum.sv
rtl/core/sse_queue.sv
rtl/core/sse_calc.sv
rtl/core/sample_statistics_engine.sv
tb/sample_statistics_engine_tb.sv
